>>> rtl/core/frlh_pkg.sv
// ----------------------------------------------------------------------------
// frlh_pkg: shared types and constants of the flash ring log head controller
// Item layouts, operation and action codes, ring geometry and remainder unit
// handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package frlh_pkg;

   // ring geometry
   localparam int SECTOR_BITS      = 6;
   localparam int SLOTS_PER_SECTOR = 1 << SECTOR_BITS;
   localparam int MAX_SLOTS        = 65536;
   localparam int SLOT_W           = 16;
   localparam int RING_W           = 17;
   localparam int SECT_W           = RING_W - SECTOR_BITS;
   localparam int REM_CNT_W        = $clog2(SECT_W + 1);
   localparam int RING_LIMIT       = (MAX_SLOTS < 65536) ? MAX_SLOTS : 65536;

   // record words
   localparam logic [31:0] LOG_MAGIC  = 32'h3158_4242;
   localparam logic [31:0] BLANK_WORD = 32'hffff_ffff;

   // register reset values
   localparam logic [RING_W-1:0] RING_SLOTS_RESET  = 17'd4096;
   localparam logic [31:0]       BOOT_NUMBER_RESET = 32'd0;

   // register decode on paddr[2]
   localparam logic REG_RING_SLOTS  = 1'b0;
   localparam logic REG_BOOT_NUMBER = 1'b1;
   localparam int   CSR_ADDR_W      = 3;

   // result queue
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_SCAN     = 2'd0,
      OP_SCAN_END = 2'd1,
      OP_PROBE    = 2'd2,
      OP_APPEND   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_READY = 2'd0,
      ACT_PROBE = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_WRITE = 2'd3
   } action_type;

   typedef struct packed {
      op_type      opcode;
      logic [15:0] slot_index;
      logic [31:0] record_magic;
      logic [31:0] record_boot;
      logic [31:0] record_seq;
      logic [7:0]  event_kind;
      logic [15:0] event_code;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] slot;
      logic [31:0] stamp_boot;
      logic [31:0] stamp_seq;
      logic [7:0]  kind_out;
      logic [15:0] code_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [SECT_W-1:0] dividend;
      logic [SECT_W-1:0] divisor;
   } rem_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [SECT_W-1:0] remainder;
   } rem_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/frlh_chan_if.sv
// ----------------------------------------------------------------------------
// frlh_chan_if: valid/ready channel
// Carries one item per handshake with a payload of the given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface frlh_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/frlh_rem.sv
// ----------------------------------------------------------------------------
// frlh_rem: iterative remainder unit
// Restoring remainder of two sector counts, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frlh_rem (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire frlh_pkg::rem_req_type rem_req,
   output frlh_pkg::rem_rsp_type      rem_rsp
);

   localparam int W = frlh_pkg::SECT_W;
   localparam int C = frlh_pkg::REM_CNT_W;

   logic         active_ff, active_in;
   logic         done_ff, done_in;
   logic [C-1:0] count_ff, count_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] div_ff, div_in;
   logic [W:0]   trial;
   logic [W:0]   diff;

   always_comb begin
      trial     = {rem_ff, quo_ff[W-1]};
      diff      = trial - {1'b0, div_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (rem_req.start) begin
         active_in = 1'b1;
         count_in  = C'(W);
         rem_in    = '0;
         quo_in    = rem_req.dividend;
         div_in    = rem_req.divisor;
      end else if (active_ff) begin
         rem_in   = (trial >= {1'b0, div_ff}) ? diff[W-1:0] : trial[W-1:0];
         quo_in   = {quo_ff[W-2:0], 1'b0};
         count_in = count_ff - C'(1);
         if (count_ff == C'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign rem_rsp.busy      = active_ff | done_ff;
   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/core/flash_ring_log_head_controller.sv
// ----------------------------------------------------------------------------
// flash_ring_log_head_controller: write head manager for a flash log ring
// Tracks the newest valid record during a scan, places and probes the head,
// and turns append items into erase and write commands.
// ----------------------------------------------------------------------------
// results: an accepted item writes its results into the registered result queue, except below
// throughput: one item per cycle unless req stalls, bounded by one result per cycle on rsp
// a scan end after a found record offers its result once the remainder unit is done:
//   an 11-step remainder over the ring's sector count wraps the head, req stalls
// reset: head, sequence counter, scan tracking and result queue cleared,
//   ring_slots back to 4096, boot_number back to 0
// ----------------------------------------------------------------------------
`default_nettype none

module flash_ring_log_head_controller (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   frlh_chan_if.sink                                    req_chan,
   frlh_chan_if.source                                  rsp_chan,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [frlh_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  wire logic [31:0]                             csr_pwdata,
   output logic      [31:0]                             csr_prdata,
   output logic                                         csr_pready
);

   localparam int SB = frlh_pkg::SECTOR_BITS;
   localparam int SW = frlh_pkg::SLOT_W;
   localparam int RW = frlh_pkg::RING_W;
   localparam int QW = frlh_pkg::SECT_W;
   localparam int PW = frlh_pkg::RSP_PTR_W;
   localparam int CW = frlh_pkg::RSP_CNT_W;

   // configuration registers
   logic [RW-1:0] ring_slots_ff;
   logic [31:0]   boot_number_ff;
   logic          csr_wr;

   // block state
   logic [SW-1:0] head_ff, head_in;
   logic [31:0]   seq_ff, seq_in;
   logic [31:0]   lead_boot_ff, lead_boot_in;
   logic [31:0]   lead_seq_ff, lead_seq_in;
   logic [SW-1:0] lead_slot_ff, lead_slot_in;
   logic          found_ff, found_in;
   logic [SB-1:0] low_ff, low_in;

   // result queue
   frlh_pkg::rsp_type q_ff [frlh_pkg::RSP_DEPTH];
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    push_cnt;
   frlh_pkg::rsp_type push0, push1;
   logic          pop;

   // derived ring geometry
   logic [RW-1:0] ring_clamp;
   logic [RW-1:0] ring_n;
   logic [QW-1:0] sect_n;
   logic [SW-1:0] head_eff;

   logic                  req_fire;
   frlh_pkg::req_type     req;
   frlh_pkg::rem_req_type rem_req;
   frlh_pkg::rem_rsp_type rem_rsp;

   function automatic frlh_pkg::rsp_type mk_rsp(frlh_pkg::action_type act,
                                                logic [SW-1:0] slot,
                                                logic last);
      frlh_pkg::rsp_type r;
      r            = '0;
      r.action     = act;
      r.slot       = slot;
      r.last       = last;
      return r;
   endfunction

   frlh_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         frlh_pkg::REG_RING_SLOTS:  csr_prdata = {{(32-RW){1'b0}}, ring_slots_ff};
         frlh_pkg::REG_BOOT_NUMBER: csr_prdata = boot_number_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_slots_ff  <= frlh_pkg::RING_SLOTS_RESET;
         boot_number_ff <= frlh_pkg::BOOT_NUMBER_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            frlh_pkg::REG_RING_SLOTS:  ring_slots_ff  <= csr_pwdata[RW-1:0];
            frlh_pkg::REG_BOOT_NUMBER: boot_number_ff <= csr_pwdata;
            default:                   ring_slots_ff  <= ring_slots_ff;
         endcase
      end
   end

   // ring size: clamp, round down to whole sectors, at least one sector
   always_comb begin
      ring_clamp = (ring_slots_ff > RW'(frlh_pkg::RING_LIMIT)) ?
                   RW'(frlh_pkg::RING_LIMIT) : ring_slots_ff;
      ring_n     = {ring_clamp[RW-1:SB], {SB{1'b0}}};
      if (ring_clamp[RW-1:SB] == '0) begin
         ring_n = RW'(frlh_pkg::SLOTS_PER_SECTOR);
      end
      sect_n   = ring_n[RW-1:SB];
      head_eff = ({1'b0, head_ff} >= ring_n) ? '0 : head_ff;
   end

   assign req          = req_chan.payload;
   assign req_chan.ready = !rem_rsp.busy && (count_ff <= CW'(frlh_pkg::RSP_DEPTH - 2));
   assign req_fire     = req_chan.valid && req_chan.ready;

   // item processing
   always_comb begin
      logic [RW-1:0] slot_next;
      logic [QW-1:0] sect_next;
      logic [RW-1:0] head_inc;
      logic [SW-1:0] done_head;

      slot_next    = {1'b0, lead_slot_ff} + RW'(1);
      sect_next    = {1'b0, head_eff[SW-1:SB]} + QW'(1);
      head_inc     = {1'b0, head_eff} + RW'(1);
      done_head    = {rem_rsp.remainder[QW-2:0], low_ff};

      head_in      = head_ff;
      seq_in       = seq_ff;
      lead_boot_in = lead_boot_ff;
      lead_seq_in  = lead_seq_ff;
      lead_slot_in = lead_slot_ff;
      found_in     = found_ff;
      low_in       = low_ff;
      push_cnt     = 2'd0;
      push0        = '0;
      push1        = '0;
      rem_req      = '0;

      if (rem_rsp.done) begin
         head_in  = done_head;
         push_cnt = 2'd1;
         push0    = mk_rsp((low_ff != '0) ? frlh_pkg::ACT_PROBE : frlh_pkg::ACT_READY,
                           done_head, 1'b1);
      end else if (req_fire) begin
         case (req.opcode)
            frlh_pkg::OP_SCAN: begin
               if (req.record_magic == frlh_pkg::LOG_MAGIC &&
                   (!found_ff || req.record_boot > lead_boot_ff ||
                    (req.record_boot == lead_boot_ff && req.record_seq > lead_seq_ff)))
               begin
                  found_in     = 1'b1;
                  lead_boot_in = req.record_boot;
                  lead_seq_in  = req.record_seq;
                  lead_slot_in = req.slot_index;
               end
            end
            frlh_pkg::OP_SCAN_END: begin
               found_in     = 1'b0;
               lead_boot_in = '0;
               lead_seq_in  = '0;
               lead_slot_in = '0;
               if (found_ff) begin
                  rem_req.start    = 1'b1;
                  rem_req.dividend = slot_next[RW-1:SB];
                  rem_req.divisor  = sect_n;
                  low_in           = slot_next[SB-1:0];
               end else begin
                  head_in  = '0;
                  push_cnt = 2'd1;
                  push0    = mk_rsp(frlh_pkg::ACT_READY, '0, 1'b1);
               end
            end
            frlh_pkg::OP_PROBE: begin
               head_in = head_eff;
               if (head_eff[SB-1:0] != '0 && req.record_magic != frlh_pkg::BLANK_WORD) begin
                  head_in = (sect_next == sect_n) ? '0 : {sect_next[QW-2:0], {SB{1'b0}}};
               end
               push_cnt = 2'd1;
               push0    = mk_rsp(frlh_pkg::ACT_READY, head_in, 1'b1);
            end
            frlh_pkg::OP_APPEND: begin
               seq_in           = seq_ff + 32'd1;
               push1            = mk_rsp(frlh_pkg::ACT_WRITE, head_eff, 1'b1);
               push1.stamp_boot = boot_number_ff;
               push1.stamp_seq  = seq_in;
               push1.kind_out   = req.event_kind;
               push1.code_out   = req.event_code;
               if (head_eff[SB-1:0] == '0) begin
                  push_cnt = 2'd2;
                  push0    = mk_rsp(frlh_pkg::ACT_ERASE, head_eff, 1'b0);
               end else begin
                  push_cnt = 2'd1;
                  push0    = push1;
               end
               head_in = (head_inc == ring_n) ? '0 : head_inc[SW-1:0];
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         seq_ff       <= '0;
         lead_boot_ff <= '0;
         lead_seq_ff  <= '0;
         lead_slot_ff <= '0;
         found_ff     <= 1'b0;
      end else begin
         head_ff      <= head_in;
         seq_ff       <= seq_in;
         lead_boot_ff <= lead_boot_in;
         lead_seq_ff  <= lead_seq_in;
         lead_slot_ff <= lead_slot_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff <= low_in;
   end

   // result queue
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.payload = q_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PW'(push_cnt);
      count_in  = count_ff + CW'(push_cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wr_ptr_ff + PW'(1)] <= push1;
      end
   end

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(frlh_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_rem_release: assert property (@(posedge clock) disable iff (reset)
      rem_rsp.done |=> !rem_rsp.busy)
      else $error("remainder unit still busy after done");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.last |->
         rsp_chan.payload.action == frlh_pkg::ACT_ERASE)
      else $error("non-final result is not an erase");

endmodule

`default_nettype wire

>>> test/tb_flash_ring_log_head_controller.sv
// ----------------------------------------------------------------------------
// tb_flash_ring_log_head_controller: self-checking bench of the log head block
// Drives scan, scan end, probe and append items with random bursts and gaps,
// stalls the result side on its own pattern, and checks every result against
// a predictor of the head, sequence and scan tracking across ring resizes.
// ----------------------------------------------------------------------------

module tb_flash_ring_log_head_controller;

   localparam int ITEM_TARGET = 1350;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES = 100;

   class head_action_board;
      frlh_pkg::rsp_type pending_actions[$];
      logic [16:0]       ring_slots_val;
      logic [31:0]       boot_val;
      logic [15:0]       head_slot;
      logic [31:0]       seq_count;
      logic [31:0]       lead_boot;
      logic [31:0]       lead_seq;
      logic [15:0]       lead_slot;
      logic              found_any;
      int                mismatches;

      function new();
         ring_slots_val = frlh_pkg::RING_SLOTS_RESET;
         boot_val       = frlh_pkg::BOOT_NUMBER_RESET;
         head_slot      = '0;
         seq_count      = '0;
         lead_boot      = '0;
         lead_seq       = '0;
         lead_slot      = '0;
         found_any      = 1'b0;
         mismatches     = 0;
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      function int pending();
         return pending_actions.size();
      endfunction

      function int unsigned ring_count();
         int unsigned n;
         n = ring_slots_val;
         if (n > frlh_pkg::RING_LIMIT) n = frlh_pkg::RING_LIMIT;
         n = n - n % frlh_pkg::SLOTS_PER_SECTOR;
         if (n < frlh_pkg::SLOTS_PER_SECTOR) n = frlh_pkg::SLOTS_PER_SECTOR;
         return n;
      endfunction

      function void note_config(logic sel, logic [31:0] data);
         if (sel == frlh_pkg::REG_RING_SLOTS) ring_slots_val = data[16:0];
         else boot_val = data;
      endfunction

      function void queue_action(frlh_pkg::action_type act, logic [15:0] slot,
                                 logic [31:0] sb, logic [31:0] sq, logic [7:0] kind,
                                 logic [15:0] code, logic last);
         frlh_pkg::rsp_type a;
         a.action     = act;
         a.slot       = slot;
         a.stamp_boot = sb;
         a.stamp_seq  = sq;
         a.kind_out   = kind;
         a.code_out   = code;
         a.last       = last;
         pending_actions.push_back(a);
      endfunction

      function void apply_request(frlh_pkg::req_type r);
         int unsigned n;
         int unsigned sps;
         int unsigned next;
         n   = ring_count();
         sps = frlh_pkg::SLOTS_PER_SECTOR;
         case (r.opcode)
            frlh_pkg::OP_SCAN: begin
               if (r.record_magic == frlh_pkg::LOG_MAGIC &&
                   (!found_any || r.record_boot > lead_boot ||
                   (r.record_boot == lead_boot && r.record_seq > lead_seq))) begin
                  found_any = 1'b1;
                  lead_boot = r.record_boot;
                  lead_seq  = r.record_seq;
                  lead_slot = r.slot_index;
               end
            end
            frlh_pkg::OP_SCAN_END: begin
               next = lead_slot;
               next = found_any ? (next + 1) % n : 0;
               head_slot = 16'(next);
               found_any = 1'b0;
               lead_boot = '0;
               lead_seq  = '0;
               lead_slot = '0;
               queue_action((head_slot % sps != 0) ? frlh_pkg::ACT_PROBE :
                            frlh_pkg::ACT_READY, head_slot, '0, '0, '0, '0, 1'b1);
            end
            frlh_pkg::OP_PROBE: begin
               if (head_slot >= n) head_slot = '0;
               if (head_slot % sps != 0 && r.record_magic != frlh_pkg::BLANK_WORD) begin
                  next = head_slot / sps;
                  next = ((next + 1) % (n / sps)) * sps;
                  head_slot = 16'(next);
               end
               queue_action(frlh_pkg::ACT_READY, head_slot, '0, '0, '0, '0, 1'b1);
            end
            default: begin
               if (head_slot >= n) head_slot = '0;
               seq_count = seq_count + 1;
               if (head_slot % sps == 0)
                  queue_action(frlh_pkg::ACT_ERASE, head_slot, '0, '0, '0, '0, 1'b0);
               queue_action(frlh_pkg::ACT_WRITE, head_slot, boot_val, seq_count,
                            r.event_kind, r.event_code, 1'b1);
               next = head_slot;
               head_slot = 16'((next + 1) % n);
            end
         endcase
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_action(frlh_pkg::rsp_type got);
         frlh_pkg::rsp_type want;
         if (pending_actions.size() == 0) begin
            report($sformatf("result with nothing pending, action %0d slot %0d",
                             got.action, got.slot));
            return;
         end
         want = pending_actions.pop_front();
         compare_field("action", 32'(got.action), 32'(want.action));
         compare_field("slot", 32'(got.slot), 32'(want.slot));
         compare_field("stamp_boot", got.stamp_boot, want.stamp_boot);
         compare_field("stamp_seq", got.stamp_seq, want.stamp_seq);
         compare_field("kind_out", 32'(got.kind_out), 32'(want.kind_out));
         compare_field("code_out", 32'(got.code_out), 32'(want.code_out));
         compare_field("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [frlh_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   frlh_chan_if #(.payload_type(frlh_pkg::req_type)) req_if ();
   frlh_chan_if #(.payload_type(frlh_pkg::rsp_type)) rsp_if ();

   head_action_board board = new();

   int items_sent = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit hold_off_req = 1'b0;

   flash_ring_log_head_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle limit
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // result side stalls
   initial begin
      int seg_left;
      int seg_mode;
      seg_left = 0;
      seg_mode = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 9);
            seg_left = (seg_mode < 2) ? $urandom_range(30, 80) :
                       (seg_mode < 4) ? $urandom_range(1, 6) : $urandom_range(5, 20);
         end
         seg_left--;
         if (seg_mode < 2) rsp_if.ready <= 1'b1;
         else if (seg_mode < 4) rsp_if.ready <= 1'b0;
         else rsp_if.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_action(rsp_if.payload);
   end

   function automatic frlh_pkg::req_type noise_item();
      frlh_pkg::req_type r;
      r.opcode       = frlh_pkg::op_type'(2'($urandom_range(0, 3)));
      r.slot_index   = 16'($urandom);
      r.record_magic = $urandom;
      r.record_boot  = $urandom;
      r.record_seq   = $urandom;
      r.event_kind   = 8'($urandom);
      r.event_code   = 16'($urandom);
      return r;
   endfunction

   function automatic frlh_pkg::req_type scan_item(logic [15:0] slot, logic [31:0] magic,
                                                   logic [31:0] boot, logic [31:0] seq);
      frlh_pkg::req_type r;
      r = noise_item();
      r.opcode       = frlh_pkg::OP_SCAN;
      r.slot_index   = slot;
      r.record_magic = magic;
      r.record_boot  = boot;
      r.record_seq   = seq;
      return r;
   endfunction

   function automatic frlh_pkg::req_type end_item();
      frlh_pkg::req_type r;
      r = noise_item();
      r.opcode = frlh_pkg::OP_SCAN_END;
      return r;
   endfunction

   function automatic frlh_pkg::req_type probe_item(logic [31:0] magic);
      frlh_pkg::req_type r;
      r = noise_item();
      r.opcode       = frlh_pkg::OP_PROBE;
      r.record_magic = magic;
      return r;
   endfunction

   function automatic frlh_pkg::req_type append_item(logic [7:0] kind, logic [15:0] code);
      frlh_pkg::req_type r;
      r = noise_item();
      r.opcode     = frlh_pkg::OP_APPEND;
      r.event_kind = kind;
      r.event_code = code;
      return r;
   endfunction

   function automatic logic [15:0] pick_slot(int unsigned n);
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'(n - 1);
         2: return 16'($urandom_range(0, n / frlh_pkg::SLOTS_PER_SECTOR - 1) *
                      frlh_pkg::SLOTS_PER_SECTOR + frlh_pkg::SLOTS_PER_SECTOR - 1);
         default: return 16'($urandom_range(0, n - 1));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         4: return 32'hffff_ffff;
         5: return $urandom;
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [31:0] pick_magic(int blank_weight);
      int r;
      r = $urandom_range(0, 9);
      if (r < blank_weight) return frlh_pkg::BLANK_WORD;
      if (r < 7) return frlh_pkg::LOG_MAGIC;
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_ring();
      case ($urandom_range(0, 7))
         0: return 32'd64;
         1: return 32'd4096;
         2: return 32'd65536;
         3: return 32'd131071;
         4: return $urandom_range(0, 63);
         5: return $urandom_range(65, 2000);
         6: return $urandom_range(1, 32) * frlh_pkg::SLOTS_PER_SECTOR;
         default: return $urandom_range(0, 131071);
      endcase
   endfunction

   // called on a falling edge, returns on a falling edge
   task automatic offer(frlh_pkg::req_type item);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      forever begin
         @(posedge clock);
         if (req_if.ready === 1'b1) break;
      end
      board.apply_request(item);
      items_sent++;
      @(negedge clock);
   endtask

   // wait until every result is back, then hold req idle before returning
   task automatic settle();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic sel, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready === 1'b1) break;
      end
      board.note_config(sel, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic scan_pass();
      int unsigned n;
      n = board.ring_count();
      repeat ($urandom_range(0, 12))
         offer(scan_item(pick_slot(n), pick_magic(1), pick_word(), pick_word()));
      offer(end_item());
      if ($urandom_range(0, 4) != 0) offer(probe_item(pick_magic(4)));
   endtask

   initial begin
      int kind;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default ring and boot after reset
      offer(append_item(8'hff, 16'hffff));
      offer(append_item(8'h00, 16'h0000));
      offer(scan_item(16'd500, frlh_pkg::BLANK_WORD, 32'hffff_ffff, 32'hffff_ffff));
      offer(scan_item(16'd100, frlh_pkg::LOG_MAGIC, 32'd5, 32'd7));
      offer(scan_item(16'd200, frlh_pkg::LOG_MAGIC, 32'd5, 32'd6));
      offer(scan_item(16'd300, frlh_pkg::LOG_MAGIC, 32'd5, 32'd7));
      offer(scan_item(16'd400, frlh_pkg::LOG_MAGIC, 32'd4, 32'hffff_ffff));
      offer(end_item());
      offer(probe_item(frlh_pkg::BLANK_WORD));
      offer(probe_item(32'd0));
      offer(probe_item(32'd0));
      offer(end_item());
      offer(scan_item(16'hffff, frlh_pkg::LOG_MAGIC, 32'hffff_ffff, 32'hffff_ffff));
      offer(end_item());
      offer(scan_item(16'd63, frlh_pkg::LOG_MAGIC, 32'd0, 32'd0));
      offer(end_item());
      offer(scan_item(16'd4094, frlh_pkg::LOG_MAGIC, 32'd1, 32'd1));
      offer(end_item());
      offer(probe_item(frlh_pkg::LOG_MAGIC));
      offer(scan_item(16'd999, frlh_pkg::LOG_MAGIC, 32'd2, 32'd2));
      offer(end_item());

      // head left outside a shrunken ring
      settle();
      csr_write(frlh_pkg::REG_RING_SLOTS, 32'd64);
      csr_write(frlh_pkg::REG_BOOT_NUMBER, 32'hffff_ffff);
      offer(probe_item(32'd0));
      offer(append_item(8'h5a, 16'ha5a5));
      offer(append_item(8'ha5, 16'h5a5a));

      // oversized ring value keeps only its low 17 bits and rounds down to whole sectors
      settle();
      csr_write(frlh_pkg::REG_RING_SLOTS, 32'hfffe_ffff);
      offer(scan_item(16'd65534, frlh_pkg::LOG_MAGIC, 32'd7, 32'd7));
      offer(end_item());
      offer(probe_item(32'd1));

      // result side held off while appends keep coming
      settle();
      hold_off_req = 1'b1;
      gaps_on = 1'b0;
      repeat (30) offer(append_item(8'($urandom), 16'($urandom)));
      settle();

      while (items_sent < ITEM_TARGET) begin
         settle();
         if ($urandom_range(0, 2) != 0)
            csr_write(frlh_pkg::REG_RING_SLOTS, {15'($urandom), 17'(pick_ring())});
         if ($urandom_range(0, 2) == 0)
            csr_write(frlh_pkg::REG_BOOT_NUMBER, ($urandom_range(0, 1) != 0) ? $urandom :
                      (($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'd0));
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(4, 10)) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) scan_pass();
            else if (kind < 8)
               repeat ($urandom_range(1, 20)) offer(append_item(8'($urandom), 16'($urandom)));
            else if (kind == 8) repeat ($urandom_range(1, 4)) offer(noise_item());
            else offer(probe_item(pick_magic(4)));
         end
      end

      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
